// ----- design/psm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants for the path segment predicate matcher
// Holds the request payload structs, the configuration bundle and the codes
// used by the match logic and the configuration port.
// ----------------------------------------------------------------------------
package psm_pkg;

  // Default width of the per-path segment position counter.
  localparam int unsigned CounterBitsDef = 16;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Register widths.
  localparam int unsigned ModeW  = 7;
  localparam int unsigned ShortW = 16;
  localparam int unsigned WordW  = 64;

  // Bit positions inside match_mode.
  localparam int unsigned ModeNegateBit = 0;
  localparam int unsigned ModeLabelBit  = 1;
  localparam int unsigned ModeNameBit   = 2;
  localparam int unsigned ModeFieldBit  = 3;
  localparam int unsigned ModeIndexBit  = 4;
  localparam int unsigned ModeStepsLsb  = 5;
  localparam int unsigned ModeStepsMsb  = 6;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MATCH_MODE   = 3'd0,
    REG_TARGET_LABEL = 3'd1,
    REG_TARGET_NAME  = 3'd2,
    REG_TARGET_FIELD = 3'd3,
    REG_TARGET_INDEX = 3'd4,
    REG_TARGET_STEPS = 3'd5,
    REG_EXTRA_WORD   = 3'd6
  } cfg_reg_e;

  // Operator applied to the segment position.
  typedef enum logic [1:0] {
    STEPS_NONE = 2'd0,
    STEPS_LT   = 2'd1,
    STEPS_GT   = 2'd2,
    STEPS_EQ   = 2'd3
  } steps_op_e;

  // One incoming path segment.
  typedef struct packed {
    logic        [WordW-1:0]  group_id;
    logic        [WordW-1:0]  def_id;
    logic signed [WordW-1:0]  name_id;
    logic        [WordW-1:0]  position;
    logic        [ShortW-1:0] seg_label;
    logic        [ShortW-1:0] field_id;
    logic        [ShortW-1:0] child_index;
    logic                     last_segment;
  } seg_req_t;

  // One match result.
  typedef struct packed {
    logic                    found;
    logic signed [WordW-1:0] extra_out;
    logic        [WordW-1:0] group_id_out;
    logic        [WordW-1:0] def_id_out;
    logic        [WordW-1:0] position_out;
  } match_rsp_t;

  // Configured predicate, handed to the match logic as one bundle.
  typedef struct packed {
    logic        [ModeW-1:0]  match_mode;
    logic        [ShortW-1:0] target_label;
    logic signed [WordW-1:0]  target_name;
    logic        [ShortW-1:0] target_field;
    logic        [ShortW-1:0] target_index;
    logic        [ShortW-1:0] target_steps;
    logic signed [WordW-1:0]  extra_word;
  } match_cfg_t;

endpackage
`default_nettype wire

// ----- design/psm_predicate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psm_predicate: segment predicate evaluation
// Compares one segment against the configured targets and its position in
// the path under the steps operator. Purely combinational.
// ----------------------------------------------------------------------------
module psm_predicate #(
  parameter int unsigned COUNTER_BITS = psm_pkg::CounterBitsDef
) (
  input  var psm_pkg::match_cfg_t cfg_i,
  input  var psm_pkg::seg_req_t   seg_i,
  input  wire [COUNTER_BITS-1:0]  pos_i,
  output logic                    pass_o
);

  localparam int unsigned CmpW =
    (COUNTER_BITS > psm_pkg::ShortW) ? COUNTER_BITS : psm_pkg::ShortW;

  logic                 negate;
  logic                 name_ok, label_ok, field_ok, index_ok, steps_ok;
  logic [CmpW-1:0]      pos_ext, steps_ext;
  psm_pkg::steps_op_e   steps_op;

  assign negate   = cfg_i.match_mode[psm_pkg::ModeNegateBit];
  assign steps_op = psm_pkg::steps_op_e'(
    cfg_i.match_mode[psm_pkg::ModeStepsMsb:psm_pkg::ModeStepsLsb]);
  assign pos_ext   = CmpW'(pos_i);
  assign steps_ext = CmpW'(cfg_i.target_steps);

  // Field compares; negate inverts every enabled equality test.
  assign name_ok  = !cfg_i.match_mode[psm_pkg::ModeNameBit] ||
                    ((seg_i.name_id == cfg_i.target_name) ^ negate);
  assign label_ok = !cfg_i.match_mode[psm_pkg::ModeLabelBit] ||
                    ((seg_i.seg_label == cfg_i.target_label) ^ negate);
  assign field_ok = !cfg_i.match_mode[psm_pkg::ModeFieldBit] ||
                    ((seg_i.field_id == cfg_i.target_field) ^ negate);
  assign index_ok = !cfg_i.match_mode[psm_pkg::ModeIndexBit] ||
                    ((seg_i.child_index == cfg_i.target_index) ^ negate);

  // Position compare, unaffected by negate.
  always_comb begin
    case (steps_op)
      psm_pkg::STEPS_NONE: steps_ok = 1'b1;
      psm_pkg::STEPS_LT:   steps_ok = pos_ext < steps_ext;
      psm_pkg::STEPS_GT:   steps_ok = pos_ext > steps_ext;
      psm_pkg::STEPS_EQ:   steps_ok = pos_ext == steps_ext;
      default:             steps_ok = 1'b1;
    endcase
  end

  assign pass_o = name_ok && label_ok && field_ok && index_ok && steps_ok;

endmodule
`default_nettype wire

// ----- design/path_segment_predicate_match_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A request passes through the input register and then the result register
// before its result leaves the block.
// Throughput: one segment per cycle; the only bubble comes from a stalled
// result register, which holds the input register until the result leaves.
// Reset clears all configuration registers, the position counter, the match
// flag and both valid bits.
// ----------------------------------------------------------------------------
// path_segment_predicate_match_core: first-match search along a path
// Tests every segment of a path against the configured predicate and reports
// the first passing segment, or a not-found result on the last segment.
// ----------------------------------------------------------------------------
module path_segment_predicate_match_core #(
  parameter int unsigned COUNTER_BITS = psm_pkg::CounterBitsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Segment requests
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  var psm_pkg::seg_req_t           in_data_i,
  // Match results
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output psm_pkg::match_rsp_t             out_data_o,
  // Configuration writes
  input  wire                             cfg_we_i,
  input  wire [psm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [psm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam logic [COUNTER_BITS-1:0] CounterMax = {COUNTER_BITS{1'b1}};

  psm_pkg::match_cfg_t          cfg_q;
  psm_pkg::seg_req_t            seg_q;
  logic                         seg_valid_q;
  psm_pkg::match_rsp_t          rsp_q, rsp_d;
  logic                         out_valid_q;
  logic [COUNTER_BITS-1:0]      counter_q, counter_d;
  logic                         path_done_q, path_done_d;
  logic                         pass;
  logic                         emits;
  logic                         out_free;
  logic                         seg_adv;
  logic                         out_load;
  logic                         in_accept;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (psm_pkg::cfg_reg_e'(cfg_idx_i))
        psm_pkg::REG_MATCH_MODE:   cfg_q.match_mode   <= cfg_data_i[psm_pkg::ModeW-1:0];
        psm_pkg::REG_TARGET_LABEL: cfg_q.target_label <= cfg_data_i[psm_pkg::ShortW-1:0];
        psm_pkg::REG_TARGET_NAME:  cfg_q.target_name  <= cfg_data_i[psm_pkg::WordW-1:0];
        psm_pkg::REG_TARGET_FIELD: cfg_q.target_field <= cfg_data_i[psm_pkg::ShortW-1:0];
        psm_pkg::REG_TARGET_INDEX: cfg_q.target_index <= cfg_data_i[psm_pkg::ShortW-1:0];
        psm_pkg::REG_TARGET_STEPS: cfg_q.target_steps <= cfg_data_i[psm_pkg::ShortW-1:0];
        psm_pkg::REG_EXTRA_WORD:   cfg_q.extra_word   <= cfg_data_i[psm_pkg::WordW-1:0];
        default: ;
      endcase
    end
  end

  // Predicate on the registered segment.
  psm_predicate #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_predicate (
    .cfg_i  (cfg_q),
    .seg_i  (seg_q),
    .pos_i  (counter_q),
    .pass_o (pass)
  );

  // Handshake: a segment that produces no result never waits on the output.
  assign emits     = !path_done_q && (pass || seg_q.last_segment);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign seg_adv   = seg_valid_q && (!emits || out_free);
  assign out_load  = seg_adv && emits;
  assign in_stall_o = seg_valid_q && !seg_adv;
  assign in_accept = in_valid_i && !in_stall_o;

  // Result and path state for the segment leaving the input register.
  always_comb begin
    rsp_d       = '0;
    path_done_d = path_done_q;
    counter_d   = counter_q;
    if (pass && !path_done_q) begin
      rsp_d.found        = 1'b1;
      rsp_d.extra_out    = cfg_q.extra_word;
      rsp_d.group_id_out = seg_q.group_id;
      rsp_d.def_id_out   = seg_q.def_id;
      rsp_d.position_out = seg_q.position;
      path_done_d        = 1'b1;
    end
    if (seg_q.last_segment) begin
      counter_d   = '0;
      path_done_d = 1'b0;
    end else if (counter_q != CounterMax) begin
      counter_d = counter_q + 1'b1;
    end
  end

  // Input register and path state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      counter_q   <= '0;
      path_done_q <= 1'b0;
    end else begin
      if (seg_adv) begin
        counter_q   <= counter_d;
        path_done_q <= path_done_d;
      end
      if (in_accept) begin
        seg_valid_q <= 1'b1;
      end else if (seg_adv) begin
        seg_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seg_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

`ifndef SYNTHESIS
  // Once a path has matched, its remaining segments produce nothing.
  a_no_result_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_adv && path_done_q) |-> !out_load)
    else $error("result produced after a path already matched");

  // A not-found result only comes from the last segment of a path.
  a_notfound_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !rsp_d.found) |-> seg_q.last_segment)
    else $error("not-found result on a segment that is not last");

  // The position counter saturates instead of wrapping.
  a_counter_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_adv && !seg_q.last_segment && counter_q == CounterMax) |=>
    (counter_q == CounterMax))
    else $error("segment position counter wrapped");

  // Input back-pressure only arises from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without output back-pressure");
`endif

endmodule
`default_nettype wire

// ----- tb/psm_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_tb_pkg: match tracker for the path segment predicate matcher bench
// Mirrors the predicate registers, the segment position counter and the
// per-path match flag, works out the result each accepted request should
// give, and checks the results leaving the block in order.
// ----------------------------------------------------------------------------
package psm_tb_pkg;
  import psm_pkg::*;

  class path_match_tracker;
    logic [ModeW-1:0]          match_mode;
    logic [ShortW-1:0]         target_label;
    logic signed [WordW-1:0]   target_name;
    logic [ShortW-1:0]         target_field;
    logic [ShortW-1:0]         target_index;
    logic [ShortW-1:0]         target_steps;
    logic signed [WordW-1:0]   extra_word;
    logic [CounterBitsDef-1:0] seg_pos;
    bit                        path_matched;
    match_rsp_t                expected_q[$];
    int unsigned               errors;

    function new();
      match_mode   = '0;
      target_label = '0;
      target_name  = '0;
      target_field = '0;
      target_index = '0;
      target_steps = '0;
      extra_word   = '0;
      seg_pos      = '0;
      path_matched = 1'b0;
      errors       = 0;
    endfunction

    // Only the register's own width is kept; unknown indexes are dropped.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_MATCH_MODE:   match_mode   = data[ModeW-1:0];
        REG_TARGET_LABEL: target_label = data[ShortW-1:0];
        REG_TARGET_NAME:  target_name  = data;
        REG_TARGET_FIELD: target_field = data[ShortW-1:0];
        REG_TARGET_INDEX: target_index = data[ShortW-1:0];
        REG_TARGET_STEPS: target_steps = data[ShortW-1:0];
        REG_EXTRA_WORD:   extra_word   = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predicts the result, if any, of one accepted segment request.
    function void note_segment(seg_req_t seg);
      bit         negate;
      bit         passes;
      match_rsp_t rsp;
      negate = match_mode[ModeNegateBit];
      passes = 1'b1;
      // An enabled field compare fails when equality agrees with negate.
      if (match_mode[ModeNameBit] && ((seg.name_id == target_name) == negate))
        passes = 1'b0;
      if (match_mode[ModeLabelBit] && ((seg.seg_label == target_label) == negate))
        passes = 1'b0;
      if (match_mode[ModeFieldBit] && ((seg.field_id == target_field) == negate))
        passes = 1'b0;
      if (match_mode[ModeIndexBit] && ((seg.child_index == target_index) == negate))
        passes = 1'b0;
      // The position test ignores negate.
      case (steps_op_e'(match_mode[ModeStepsMsb:ModeStepsLsb]))
        STEPS_LT: if (!(seg_pos < target_steps)) passes = 1'b0;
        STEPS_GT: if (!(seg_pos > target_steps)) passes = 1'b0;
        STEPS_EQ: if (seg_pos != target_steps) passes = 1'b0;
        default: ;
      endcase

      rsp = '0;
      if (!path_matched) begin
        if (passes) begin
          rsp.found        = 1'b1;
          rsp.extra_out    = extra_word;
          rsp.group_id_out = seg.group_id;
          rsp.def_id_out   = seg.def_id;
          rsp.position_out = seg.position;
          expected_q.push_back(rsp);
          path_matched = 1'b1;
        end else if (seg.last_segment) begin
          expected_q.push_back(rsp);
        end
      end

      // The position saturates on very long paths.
      if (seg.last_segment) begin
        seg_pos      = '0;
        path_matched = 1'b0;
      end else if (seg_pos != '1) begin
        seg_pos = seg_pos + 1'b1;
      end
    endfunction

    function void compare_field(string fname, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", fname, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result against the oldest prediction.
    function void check_match(match_rsp_t got);
      match_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result with none expected: found=%0b group_id_out=%h",
               got.found, got.group_id_out);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("extra_out", want.extra_out, got.extra_out);
      compare_field("group_id_out", want.group_id_out, got.group_id_out);
      compare_field("def_id_out", want.def_id_out, got.def_id_out);
      compare_field("position_out", want.position_out, got.position_out);
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for path_segment_predicate_match_core
// Streams directed and random paths through the matcher under several
// predicate settings, with random gaps on both sides and a long result stall
// that backs up the request side.
// ----------------------------------------------------------------------------
module tb;
  import psm_pkg::*;
  import psm_tb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned PRESSURE_ITEMS = 40;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  seg_req_t            in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  match_rsp_t          out_data;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  path_match_tracker   sb;
  int unsigned         quiet_cycles = 0;
  bit                  calm = 1'b0;
  int unsigned         hold_reqs = 0;

  path_segment_predicate_match_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track both handshakes and count cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_match(out_data);
      if (in_valid && !in_stall) sb.note_segment(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** path_segment_predicate_match_core: FAILED **");
    $finish;
  end

  // Result side: a random stall after each result, or one long hold on demand.
  initial begin : result_sink
    int          wait_left;
    int unsigned holds_served;
    wait_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        wait_left    = LONG_HOLD;
      end else if (out_valid && !out_stall && !calm) begin
        wait_left = $urandom_range(0, 4);
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [CfgDataW-1:0] mode_word(bit negate, bit label, bit name,
                                                    bit field, bit index, steps_op_e op);
    logic [CfgDataW-1:0] w;
    w = '0;
    w[ModeNegateBit] = negate;
    w[ModeLabelBit]  = label;
    w[ModeNameBit]   = name;
    w[ModeFieldBit]  = field;
    w[ModeIndexBit]  = index;
    w[ModeStepsMsb:ModeStepsLsb] = op;
    return w;
  endfunction

  // Register values biased toward the extremes.
  function automatic logic [CfgDataW-1:0] pick_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic seg_req_t random_segment(bit last);
    seg_req_t s;
    s.group_id     = {$urandom, $urandom};
    s.def_id       = {$urandom, $urandom};
    s.name_id      = {$urandom, $urandom};
    s.position     = {$urandom, $urandom};
    s.seg_label    = 16'($urandom);
    s.field_id     = 16'($urandom);
    s.child_index  = 16'($urandom);
    s.last_segment = last;
    return s;
  endfunction

  // Compared fields equal to the targets, or all differing when inverted.
  function automatic seg_req_t hit_segment(bit last, bit invert);
    seg_req_t s;
    s = random_segment(last);
    s.seg_label   = invert ? ~sb.target_label : sb.target_label;
    s.name_id     = invert ? ~sb.target_name  : sb.target_name;
    s.field_id    = invert ? ~sb.target_field : sb.target_field;
    s.child_index = invert ? ~sb.target_index : sb.target_index;
    return s;
  endfunction

  // Each compared field independently equal, differing or random.
  function automatic seg_req_t mixed_segment(bit last);
    seg_req_t s;
    seg_req_t hit;
    seg_req_t away;
    s    = random_segment(last);
    hit  = hit_segment(last, 1'b0);
    away = hit_segment(last, 1'b1);
    case ($urandom_range(0, 3))
      0, 1: s.seg_label = hit.seg_label;
      2:    s.seg_label = away.seg_label;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1: s.name_id = hit.name_id;
      2:    s.name_id = away.name_id;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1: s.field_id = hit.field_id;
      2:    s.field_id = away.field_id;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1: s.child_index = hit.child_index;
      2:    s.child_index = away.child_index;
      default: ;
    endcase
    return s;
  endfunction

  // Writes every register once, preceded by a write to an unused index.
  task automatic program_regs(input logic [CfgDataW-1:0] mode, input logic [CfgDataW-1:0] label,
                              input logic [CfgDataW-1:0] name, input logic [CfgDataW-1:0] field,
                              input logic [CfgDataW-1:0] index, input logic [CfgDataW-1:0] steps,
                              input logic [CfgDataW-1:0] extra);
    logic [CfgDataW-1:0] vals [REG_EXTRA_WORD+1];
    vals[REG_MATCH_MODE]   = mode;
    vals[REG_TARGET_LABEL] = label;
    vals[REG_TARGET_NAME]  = name;
    vals[REG_TARGET_FIELD] = field;
    vals[REG_TARGET_INDEX] = index;
    vals[REG_TARGET_STEPS] = steps;
    vals[REG_EXTRA_WORD]   = extra;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_UNUSED;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    for (int i = 0; i <= REG_EXTRA_WORD; i++) begin
      cfg_idx  <= i[CfgIdxW-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(i[CfgIdxW-1:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one segment request after a random gap and waits for acceptance.
  task automatic send_segment(input seg_req_t seg);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_path(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_segment(mixed_segment(i == len - 1));
  endtask

  // Stop offering requests until every predicted result has left the block.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    seg_req_t    seg;
    int unsigned phase_items;
    int unsigned seg_count;
    logic [CfgDataW-1:0] mode;
    logic [CfgDataW-1:0] steps;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no compare enabled, so the first segment matches.
    seg = '1;
    seg.last_segment = 1'b0;
    send_segment(seg);
    seg = '0;
    seg.last_segment = 1'b1;
    send_segment(seg);
    send_segment(random_segment(1'b1));
    wait_results_done();

    // Every field compare at its extremes, each mismatching on its own.
    program_regs(mode_word(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, STEPS_NONE), 64'hFFFF,
                 64'h8000_0000_0000_0000, '0, 64'hFFFF, '0, '1);
    send_segment(hit_segment(1'b1, 1'b0));
    seg = hit_segment(1'b0, 1'b0);
    seg.seg_label ^= 16'h0001;
    send_segment(seg);
    seg = hit_segment(1'b0, 1'b0);
    seg.name_id = ~seg.name_id;
    send_segment(seg);
    seg = hit_segment(1'b0, 1'b0);
    seg.field_id ^= 16'h8000;
    send_segment(seg);
    seg = hit_segment(1'b0, 1'b0);
    seg.child_index ^= 16'h0100;
    send_segment(seg);
    send_segment(hit_segment(1'b1, 1'b0));
    seg = hit_segment(1'b0, 1'b0);
    seg.seg_label ^= 16'h8000;
    send_segment(seg);
    seg = hit_segment(1'b1, 1'b0);
    seg.name_id ^= 64'h1;
    send_segment(seg);
    wait_results_done();

    // Negate: a single equal field blocks the match.
    program_regs(mode_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, STEPS_NONE), '0,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF, '0, '0, 64'h8000_0000_0000_0000);
    seg = hit_segment(1'b0, 1'b1);
    seg.child_index = sb.target_index;
    send_segment(seg);
    send_segment(hit_segment(1'b0, 1'b1));
    send_segment(random_segment(1'b1));
    wait_results_done();

    // Position operators; negate has no effect on them.
    program_regs(mode_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STEPS_LT), '0, '0, '0, '0, '0,
                 {$urandom, $urandom});
    send_random_path(3);
    wait_results_done();
    program_regs(mode_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, STEPS_GT), '0, '0, '0, '0, 64'd1,
                 {$urandom, $urandom});
    send_random_path(4);
    wait_results_done();
    program_regs(mode_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, STEPS_EQ), '0, '0, '0, '0,
                 64'hFFFF_FFFF_FFFF_0002, {$urandom, $urandom});
    send_random_path(3);
    wait_results_done();

    // Back pressure: the result side holds while single-segment paths pile up.
    program_regs('0, '0, '0, '0, '0, '0, {$urandom, $urandom});
    calm = 1'b1;
    hold_reqs++;
    for (int unsigned i = 0; i < PRESSURE_ITEMS; i++) send_segment(random_segment(1'b1));
    wait_results_done();
    calm = 1'b0;

    // Random phases, each with its own predicate.
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        mode = 64'h7F;
      end else if (phase == 1) begin
        mode = '0;
      end else begin
        mode = {$urandom, $urandom};
      end
      if ($urandom_range(0, 3) == 0) begin
        steps = pick_word();
      end else begin
        steps = {$urandom, 16'($urandom), 16'($urandom_range(0, 6))};
      end
      program_regs(mode, pick_word(), pick_word(), pick_word(), pick_word(), steps,
                   pick_word());
      calm = (phase == 2);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        seg_count = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                : $urandom_range(1, 6);
        send_random_path(seg_count);
        phase_items += seg_count;
      end
      wait_results_done();
    end

    if (sb.errors == 0) begin
      $display("** path_segment_predicate_match_core: PASSED **");
    end else begin
      $display("** path_segment_predicate_match_core: FAILED **");
    end
    $finish;
  end

endmodule
